// ===== design/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

   localparam int FRAC_BITS          = 8;
   localparam int WORD_W             = 32;
   localparam int PROD_W             = 2 * WORD_W;
   localparam int REM_W              = 2 * WORD_W + 1;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = WORD_W / DIV_BITS_PER_STAGE;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_EQ       = 4'd4,
      CMD_NE       = 4'd5,
      CMD_GT       = 4'd6,
      CMD_GE       = 4'd7,
      CMD_LT       = 4'd8,
      CMD_LE       = 4'd9,
      CMD_MIN      = 4'd10,
      CMD_MAX      = 4'd11,
      CMD_INC      = 4'd12,
      CMD_DEC      = 4'd13,
      CMD_FROM_INT = 4'd14,
      CMD_TO_INT   = 4'd15
   } cmd_type;

   typedef struct packed {
      logic [3:0]               cmd;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_raw;
      logic                     compare_true;
      logic                     overflow;
      logic                     divide_by_zero;
   } rsp_type;

   // divider pipeline payload; rsp holds the final answer when active is low
   typedef struct packed {
      rsp_type             rsp;
      logic                active;
      logic                neg;
      logic [REM_W-1:0]    rem;
      logic [REM_W-1:0]    den;
      logic [WORD_W-1:0]   quot;
   } divp_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              ovf;
   } sat_type;

   // sign and magnitude to a saturated word
   function automatic sat_type from_mag(input logic neg, input logic [PROD_W-1:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (neg) begin
         if (mag > PROD_W'({1'b1, {(WORD_W-1){1'b0}}})) begin
            r.ovf   = 1'b1;
            r.value = WORD_MIN;
         end else begin
            r.value = WORD_W'(-mag[WORD_W-1:0]);
         end
      end else begin
         if (mag > PROD_W'(WORD_MAX)) begin
            r.ovf   = 1'b1;
            r.value = WORD_MAX;
         end else begin
            r.value = mag[WORD_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/fpa_front.sv =====
`default_nettype none

module fpa_front
   import fpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire req_type  in_data,
   output logic          out_valid,
   output divp_type      out_data
);

   // stage A registers
   logic                      a_valid_ff, a_valid_in;
   logic [3:0]                a_cmd_ff, a_cmd_in;
   rsp_type                   a_rsp_ff, a_rsp_in;
   logic signed [PROD_W-1:0]  a_prod_ff, a_prod_in;
   logic                      a_neg_ff, a_neg_in;
   logic                      a_bz_ff, a_bz_in;
   logic [REM_W-1:0]          a_num_ff, a_num_in;
   logic [WORD_W:0]           a_den_ff, a_den_in;

   // stage B registers
   logic                      b_valid_ff, b_valid_in;
   divp_type                  b_data_ff, b_data_in;

   logic signed [WORD_W-1:0]  a, b;
   logic [WORD_W:0]           sum, diff;
   logic [PROD_W-1:0]         shl;
   logic                      lt, gt;
   logic [WORD_W-1:0]         ma, mb;

   logic [PROD_W-1:0]         pmag, prnd;
   sat_type                   msat, dsat;

   always_comb begin
      a = in_data.operand_a;
      b = in_data.operand_b;
      sum  = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      diff = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      shl  = PROD_W'({{WORD_W{a[WORD_W-1]}}, a} << FRAC_BITS);
      lt   = a < b;
      gt   = a > b;
      ma   = a[WORD_W-1] ? WORD_W'(-a) : a;
      mb   = b[WORD_W-1] ? WORD_W'(-b) : b;

      a_valid_in = in_valid;
      a_cmd_in   = in_data.cmd;
      a_prod_in  = a * b;
      a_neg_in   = a[WORD_W-1] ^ b[WORD_W-1];
      a_bz_in    = (b == '0);
      a_num_in   = (REM_W'(ma) << (FRAC_BITS + 1)) + REM_W'(mb);
      a_den_in   = {mb, 1'b0};

      a_rsp_in = '0;
      case (cmd_type'(in_data.cmd))
         CMD_ADD: begin
            a_rsp_in.overflow   = sum[WORD_W] != sum[WORD_W-1];
            a_rsp_in.result_raw = a_rsp_in.overflow ?
               (sum[WORD_W] ? WORD_MIN : WORD_MAX) : sum[WORD_W-1:0];
         end
         CMD_SUB: begin
            a_rsp_in.overflow   = diff[WORD_W] != diff[WORD_W-1];
            a_rsp_in.result_raw = a_rsp_in.overflow ?
               (diff[WORD_W] ? WORD_MIN : WORD_MAX) : diff[WORD_W-1:0];
         end
         CMD_EQ:  a_rsp_in.compare_true = (a == b);
         CMD_NE:  a_rsp_in.compare_true = (a != b);
         CMD_GT:  a_rsp_in.compare_true = gt;
         CMD_GE:  a_rsp_in.compare_true = !lt;
         CMD_LT:  a_rsp_in.compare_true = lt;
         CMD_LE:  a_rsp_in.compare_true = !gt;
         CMD_MIN: a_rsp_in.result_raw = lt ? a : b;
         CMD_MAX: a_rsp_in.result_raw = gt ? a : b;
         CMD_INC: begin
            a_rsp_in.overflow   = (a == WORD_MAX);
            a_rsp_in.result_raw = a_rsp_in.overflow ? WORD_MAX : a + 1;
         end
         CMD_DEC: begin
            a_rsp_in.overflow   = (a == WORD_MIN);
            a_rsp_in.result_raw = a_rsp_in.overflow ? WORD_MIN : a - 1;
         end
         CMD_FROM_INT: begin
            // fits only if the bits above the word all match its sign
            a_rsp_in.overflow = !((shl[PROD_W-1:WORD_W-1] == '0) ||
                                  (shl[PROD_W-1:WORD_W-1] == '1));
            a_rsp_in.result_raw = a_rsp_in.overflow ?
               (a[WORD_W-1] ? WORD_MIN : WORD_MAX) : shl[WORD_W-1:0];
         end
         CMD_TO_INT: a_rsp_in.result_raw = a >>> FRAC_BITS;
         default: a_rsp_in = '0;
      endcase
   end

   always_comb begin
      pmag = a_prod_ff[PROD_W-1] ? PROD_W'(-a_prod_ff) : a_prod_ff;
      prnd = (pmag + PROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      msat = from_mag(a_prod_ff[PROD_W-1], prnd);
      dsat = from_mag(a_neg_ff, PROD_W'(1) << WORD_W);

      b_valid_in       = a_valid_ff;
      b_data_in.rsp    = a_rsp_ff;
      b_data_in.active = 1'b0;
      b_data_in.neg    = a_neg_ff;
      b_data_in.rem    = a_num_ff;
      b_data_in.den    = REM_W'({a_den_ff, {(WORD_W-1){1'b0}}});
      b_data_in.quot   = '0;

      case (cmd_type'(a_cmd_ff))
         CMD_MUL: begin
            b_data_in.rsp.result_raw = msat.value;
            b_data_in.rsp.overflow   = msat.ovf;
         end
         CMD_DIV: begin
            if (a_bz_ff) begin
               b_data_in.rsp.divide_by_zero = 1'b1;
            end else if (a_num_ff >= REM_W'({a_den_ff, {WORD_W{1'b0}}})) begin
               // quotient needs more than a word: saturate now
               b_data_in.rsp.result_raw = dsat.value;
               b_data_in.rsp.overflow   = dsat.ovf;
            end else begin
               b_data_in.active = 1'b1;
            end
         end
         default: b_data_in.rsp = a_rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_cmd_ff  <= a_cmd_in;
      a_rsp_ff  <= a_rsp_in;
      a_prod_ff <= a_prod_in;
      a_neg_ff  <= a_neg_in;
      a_bz_ff   <= a_bz_in;
      a_num_ff  <= a_num_in;
      a_den_ff  <= a_den_in;
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

// ===== design/fpa_div.sv =====
`default_nettype none

module fpa_div
   import fpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire divp_type in_data,
   output logic          out_valid,
   output divp_type      out_data
);

   logic     valid_ff [DIV_STAGES];
   logic     valid_in [DIV_STAGES];
   divp_type pipe_ff  [DIV_STAGES];
   divp_type pipe_in  [DIV_STAGES];

   // restoring division, divisor walks right one bit per step
   function automatic divp_type div_step(input divp_type d);
      divp_type r;
      r = d;
      if (d.rem >= d.den) begin
         r.rem  = d.rem - d.den;
         r.quot = {d.quot[WORD_W-2:0], 1'b1};
      end else begin
         r.quot = {d.quot[WORD_W-2:0], 1'b0};
      end
      r.den = d.den >> 1;
      return r;
   endfunction

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         valid_in[s] = (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s - 1];
         pipe_in[s]  = (s == 0) ? in_data  : pipe_ff[(s == 0) ? 0 : s - 1];
         for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            pipe_in[s] = div_step(pipe_in[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         pipe_ff[s] <= pipe_in[s];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = pipe_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// channel   ports                   beat taken when
// -------   ---------------------   ------------------------------
// request   start, busy, req_data   start high and busy low
// response  rsp_strobe, rsp_data    rsp_strobe high (one cycle)
//
// Every command passes the same pipeline from the start beat to its strobe: two
// operand/multiply stages, 16 divider stages at two quotient bits each,
// and one output register. One command enters per cycle; busy stays low.
// Synchronous reset clears only the valid bits along the pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none

module fixed_point_alu
   import fpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   logic     front_valid, div_valid;
   divp_type front_data, div_data;

   logic     strobe_ff, strobe_in;
   rsp_type  rsp_ff, rsp_in;
   sat_type  qsat;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   fpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   always_comb begin
      qsat      = from_mag(div_data.neg, PROD_W'(div_data.quot));
      strobe_in = div_valid;
      rsp_in    = div_data.rsp;
      if (div_data.active) begin
         rsp_in.result_raw = qsat.value;
         rsp_in.overflow   = qsat.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== bench/alu_checker.sv =====
`timescale 1ns / 1ps

module alu_checker
   import fpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);

   rsp_type expected_q[$];

   assign pending = expected_q.size();

   function automatic rsp_type alu_predict(req_type rq);
      rsp_type r;
      longint a, b, v, p;
      longint unsigned m, one, num, den;
      logic neg;
      a = longint'(rq.operand_a);
      b = longint'(rq.operand_b);
      one = 64'd1 << FRAC_BITS;
      r = '0;
      v = 0;
      neg = 1'b0;
      case (cmd_type'(rq.cmd))
         CMD_ADD:      v = a + b;
         CMD_SUB:      v = a - b;
         CMD_MUL: begin
            p = a * b;
            m = (p < 0) ? -p : p;
            m = (m + (one >> 1)) >> FRAC_BITS;
            v = (p < 0) ? -longint'(m) : longint'(m);
         end
         CMD_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               num = ((a < 0) ? -a : a) << FRAC_BITS;
               den = (b < 0) ? -b : b;
               m = (2 * num + den) / (2 * den);
               neg = (a < 0) != (b < 0);
               // magnitude stays below 2^41, so signed math is safe
               v = neg ? -longint'(m) : longint'(m);
            end
         end
         CMD_EQ:       r.compare_true = (a == b);
         CMD_NE:       r.compare_true = (a != b);
         CMD_GT:       r.compare_true = (a > b);
         CMD_GE:       r.compare_true = (a >= b);
         CMD_LT:       r.compare_true = (a < b);
         CMD_LE:       r.compare_true = (a <= b);
         CMD_MIN:      v = (a < b) ? a : b;
         CMD_MAX:      v = (a > b) ? a : b;
         CMD_INC:      v = a + 1;
         CMD_DEC:      v = a - 1;
         CMD_FROM_INT: v = a * longint'(one);
         CMD_TO_INT:   v = a >>> FRAC_BITS;
         default:      v = 0;
      endcase
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         r.overflow = 1'b1;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         r.overflow = 1'b1;
      end
      r.result_raw = v[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy)
            expected_q.push_back(alu_predict(req_data));
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result_raw !== want.result_raw)
                  report_mismatch("result_raw", rsp_data.result_raw, want.result_raw);
               if (rsp_data.compare_true !== want.compare_true)
                  report_mismatch("compare_true", rsp_data.compare_true, want.compare_true);
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
               if (rsp_data.divide_by_zero !== want.divide_by_zero)
                  report_mismatch("divide_by_zero", rsp_data.divide_by_zero,
                                  want.divide_by_zero);
            end
         end
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import fpa_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   fixed_point_alu i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   alu_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff - $urandom_range(0, 3);
         1:       return 32'h8000_0000 + $urandom_range(0, 3);
         2:       return 32'(int'($urandom_range(0, 8)) - 4);
         3:       return 32'(int'($urandom_range(0, 4096)) - 2048);
         4:       return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
         5:       return 32'(-int'($urandom_range(0, 65535)));
         default: return $urandom;
      endcase
   endfunction

   // one beat; idle gaps inserted ahead of it when gaps_on is set
   task automatic send_beat(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
                            bit gaps_on);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 23) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data <= '{cmd: cmd, operand_a: a, operand_b: b};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int spin;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edges of each operation
      send_beat(CMD_ADD, 32'h7fff_ffff, 32'h1, 0);
      send_beat(CMD_SUB, 32'h8000_0000, 32'h1, 0);
      send_beat(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0);
      send_beat(CMD_MUL, 32'h0000_0180, 32'hffff_ff80, 0);
      send_beat(CMD_MUL, 32'h1, 32'h80, 0);
      send_beat(CMD_DIV, 32'h1234, 32'h0, 0);
      send_beat(CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
      send_beat(CMD_DIV, 32'h100, 32'hffff_fd00, 0);
      send_beat(CMD_DIV, 32'h7fff_ffff, 32'h1, 0);
      send_beat(CMD_EQ, 32'h5, 32'h5, 0);
      send_beat(CMD_NE, 32'h5, 32'h5, 0);
      send_beat(CMD_GT, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_beat(CMD_GE, 32'h7, 32'h7, 0);
      send_beat(CMD_LT, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_beat(CMD_LE, 32'h7, 32'h7, 1);
      send_beat(CMD_MIN, 32'h9, 32'h9, 1);
      send_beat(CMD_MAX, 32'hffff_ffff, 32'h1, 0);
      send_beat(CMD_INC, 32'h7fff_ffff, 32'h0, 0);
      send_beat(CMD_DEC, 32'h8000_0000, 32'hffff_ffff, 0);
      send_beat(CMD_FROM_INT, 32'h0080_0000, 32'h0, 0);
      send_beat(CMD_FROM_INT, 32'hff7f_ffff, 32'h0, 0);
      send_beat(CMD_TO_INT, 32'hffff_ff01, 32'h0, 0);
      send_beat(CMD_TO_INT, 32'h7fff_ffff, 32'h0, 0);

      // drain completely once mid-run
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      for (int i = 0; i < 900; i++) begin
         logic [31:0] b;
         b = pick_operand();
         if ($urandom_range(0, 15) == 0) b = '0;
         // back-to-back stretch with no gaps in the middle of the run
         send_beat(4'($urandom), pick_operand(), b, !(i >= 300 && i < 450));
      end
      start <= 1'b0;

      spin = 0;
      while (pending != 0 && spin < 10000) begin
         @(posedge clock);
         spin++;
      end
      repeat (25) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
